// ===== rtl/core/bitmap_page_run_allocator_top_assert.svh =====
// Assertion macros for the bitmap page run allocator
`ifndef BITMAP_PAGE_RUN_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_PAGE_RUN_ALLOCATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, held off during reset
`define BPRA_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("bitmap page run allocator: assertion failed");

// Next-cycle implication, held off during reset
`define BPRA_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("bitmap page run allocator: assertion failed");

`else

`define BPRA_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define BPRA_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

// ===== rtl/core/bpra_pkg.sv =====
// Shared constants, payload types and control types of the page allocator
package bpra_pkg;

    localparam int PAGE_COUNT  = 1024;
    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int LANES       = 32;
    localparam int LANE_W      = $clog2(LANES);
    localparam int MAP_WORDS   = (PAGE_COUNT + LANES - 1) / LANES;
    localparam int WORD_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PAGE_W      = $clog2(PAGE_COUNT);
    localparam int RUN_W       = $clog2(PAGE_COUNT + 1);
    localparam int PIDX_W      = WORD_W + LANE_W + 1;
    localparam int ADDR_W      = 32;
    localparam int SUM_W       = ADDR_W + 2;
    localparam int BYTES_W     = 23;
    localparam int ROUND_W     = BYTES_W + 1;
    localparam int REQ_PAGES_W = ROUND_W - PAGE_SHIFT;
    localparam int STATUS_W    = 2;

    localparam logic [SUM_W-1:0] HEAP_BYTES =
        SUM_W'(longint'(PAGE_COUNT) * longint'(PAGE_BYTES));

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BADFREE = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [ADDR_W-1:0]   address;
        logic [BYTES_W-1:0]  request_bytes;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   granted_address;
    } rsp_t;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_LOAD    = 3'd1,
        CMD_CHECK   = 3'd2,
        CMD_SCAN    = 3'd3,
        CMD_MARK    = 3'd4,
        CMD_PUBLISH = 3'd5
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic bad;
        logic alloc;
        logic empty;
        logic found;
        logic scan_last;
        logic mark_last;
    } dp_sts_t;

endpackage

// ===== rtl/core/bpra_ctrl.sv =====
// Sequencing state machine of the page allocator
module bpra_ctrl
    import bpra_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_MARK   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = CMD_NONE;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.op = CMD_CHECK;
                if (sts.bad)
                    state_next = ST_FINISH;
                else if (sts.alloc)
                    state_next = ST_SCAN;
                else if (sts.empty)
                    state_next = ST_FINISH;
                else
                    state_next = ST_MARK;
            end
            ST_SCAN:
            begin
                cmd.op = CMD_SCAN;
                if (sts.found)
                begin
                    if (sts.empty)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_MARK;
                end
                else if (sts.scan_last)
                    state_next = ST_FINISH;
            end
            ST_MARK:
            begin
                cmd.op = CMD_MARK;
                if (sts.mark_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold the result until the output register has room
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = CMD_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/bpra_dp.sv =====
// Bitmap storage, run search, range marking and result registers of the allocator
module bpra_dp
    import bpra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_sts_t           sts,
    input  req_t              in_data,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_data,
    output rsp_t              out_data
);

    logic [LANES-1:0]       map_reg [MAP_WORDS];
    logic [LANES-1:0]       map_word_next;
    logic [ADDR_W-1:0]      base_reg;
    logic                   kind_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [REQ_PAGES_W-1:0] pages_reg;
    logic [WORD_W-1:0]      word_idx_reg;
    logic [RUN_W-1:0]       carry_reg;
    logic [PAGE_W-1:0]      lo_reg;
    logic [PAGE_W-1:0]      hi_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [ADDR_W-1:0]      grant_reg;
    rsp_t                   out_reg;

    logic [ROUND_W-1:0]     round_c;
    logic [REQ_PAGES_W-1:0] load_pages_c;
    logic [SUM_W-1:0]       size_c;
    logic [SUM_W-1:0]       end_c;
    logic [SUM_W-1:0]       top_c;
    logic [ADDR_W-1:0]      diff_c;
    logic                   bad_free_c;
    logic                   oversize_c;
    logic [PAGE_W-1:0]      first_c;
    logic [PAGE_W-1:0]      free_hi_c;
    logic [RUN_W-1:0]       need_c;

    logic [LANES-1:0]       word_c;
    logic [LANES-1:0]       bits_c;
    logic [LANES-1:0]       zero_seen_c;
    logic [LANE_W-1:0]      last_zero_c [LANES];
    logic [RUN_W-1:0]       run_end_c [LANES];
    logic [LANES-1:0]       hit_c;
    logic                   found_c;
    logic [LANE_W-1:0]      sel_c;
    logic [PIDX_W-1:0]      start_c;
    logic [PAGE_W-1:0]      start_page_c;
    logic [PAGE_W-1:0]      alloc_hi_c;

    logic [LANES-1:0]       mask_c;
    logic                   dup_c;

    // round the byte count up to pages as the word comes in
    assign round_c      = ROUND_W'(in_data.request_bytes) + ROUND_W'(PAGE_BYTES - 1);
    assign load_pages_c = REQ_PAGES_W'(round_c >> PAGE_SHIFT);

    // free range checks; the byte sums are exact in SUM_W bits
    assign size_c     = SUM_W'(pages_reg) << PAGE_SHIFT;
    assign end_c      = SUM_W'(base_reg) + HEAP_BYTES;
    assign top_c      = SUM_W'(addr_reg) + size_c;
    assign diff_c     = addr_reg - base_reg;
    assign bad_free_c = (|addr_reg[PAGE_SHIFT-1:0]) || (addr_reg < base_reg) ||
                        (|diff_c[PAGE_SHIFT-1:0]) || (top_c > end_c);
    assign oversize_c = 32'(pages_reg) > 32'(PAGE_COUNT);
    assign first_c    = PAGE_W'(diff_c >> PAGE_SHIFT);
    assign free_hi_c  = PAGE_W'(32'(first_c) + 32'(pages_reg) - 32'd1);
    assign need_c     = RUN_W'(pages_reg);

    // one bitmap word per cycle; pages past the heap end count as used
    assign word_c = map_reg[word_idx_reg];

    always_comb
    begin
        for (int p = 0; p < LANES; p++)
        begin
            bits_c[p] = word_c[p] &&
                        (PIDX_W'({word_idx_reg, LANE_W'(p)}) < PIDX_W'(PAGE_COUNT));
        end
    end

    // run length ending at each lane, continuing the run carried from lower words
    always_comb
    begin
        for (int p = 0; p < LANES; p++)
        begin
            zero_seen_c[p] = 1'b0;
            last_zero_c[p] = '0;
            for (int q = 0; q <= p; q++)
            begin
                if (!bits_c[q])
                begin
                    zero_seen_c[p] = 1'b1;
                    last_zero_c[p] = LANE_W'(q);
                end
            end
            run_end_c[p] = zero_seen_c[p] ?
                           RUN_W'(LANE_W'(p) - last_zero_c[p]) :
                           RUN_W'(carry_reg + RUN_W'(p + 1));
            hit_c[p]     = bits_c[p] && (run_end_c[p] >= need_c);
        end
    end

    always_comb
    begin
        found_c = 1'b0;
        sel_c   = '0;
        for (int p = LANES - 1; p >= 0; p--)
        begin
            if (hit_c[p])
            begin
                found_c = 1'b1;
                sel_c   = LANE_W'(p);
            end
        end
    end

    assign start_c      = PIDX_W'({word_idx_reg, sel_c}) + PIDX_W'(1) -
                          PIDX_W'(run_end_c[sel_c]);
    assign start_page_c = PAGE_W'(start_c);
    assign alloc_hi_c   = PAGE_W'(start_c + PIDX_W'(need_c) - PIDX_W'(1));

    // lanes of the current word that fall inside the run being marked
    always_comb
    begin
        for (int p = 0; p < LANES; p++)
        begin
            mask_c[p] = (PIDX_W'({word_idx_reg, LANE_W'(p)}) >= PIDX_W'(lo_reg)) &&
                        (PIDX_W'({word_idx_reg, LANE_W'(p)}) <= PIDX_W'(hi_reg));
        end
    end

    assign dup_c         = |(word_c & mask_c);
    assign map_word_next = (kind_reg == KIND_FREE) ? (word_c | mask_c) : (word_c & ~mask_c);

    assign sts.bad       = (kind_reg == KIND_FREE) ? bad_free_c : oversize_c;
    assign sts.alloc     = (kind_reg == KIND_ALLOC);
    assign sts.empty     = (pages_reg == '0);
    assign sts.found     = found_c;
    assign sts.scan_last = (word_idx_reg == WORD_W'(MAP_WORDS - 1));
    assign sts.mark_last = ((PIDX_W'(hi_reg) >> LANE_W) == PIDX_W'(word_idx_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            for (int w = 0; w < MAP_WORDS; w++)
            begin
                map_reg[w] <= '1;
            end
        end
        else
        begin
            if (cfg_we)
                base_reg <= cfg_data;
            if (cmd.op == CMD_MARK)
                map_reg[word_idx_reg] <= map_word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_LOAD:
            begin
                kind_reg  <= in_data.kind;
                addr_reg  <= in_data.address;
                pages_reg <= load_pages_c;
            end
            CMD_CHECK:
            begin
                grant_reg <= '0;
                carry_reg <= '0;
                lo_reg    <= first_c;
                hi_reg    <= free_hi_c;
                if (kind_reg == KIND_FREE)
                begin
                    status_reg   <= bad_free_c ? STATUS_BADFREE : STATUS_OK;
                    word_idx_reg <= WORD_W'(first_c >> LANE_W);
                end
                else
                begin
                    status_reg   <= oversize_c ? STATUS_NOSPACE : STATUS_OK;
                    word_idx_reg <= '0;
                end
            end
            CMD_SCAN:
            begin
                if (found_c)
                begin
                    lo_reg       <= start_page_c;
                    hi_reg       <= alloc_hi_c;
                    word_idx_reg <= WORD_W'(start_page_c >> LANE_W);
                    grant_reg    <= base_reg + (ADDR_W'(start_page_c) << PAGE_SHIFT);
                end
                else
                begin
                    carry_reg    <= run_end_c[LANES-1];
                    word_idx_reg <= WORD_W'(word_idx_reg + 1'b1);
                    if (word_idx_reg == WORD_W'(MAP_WORDS - 1))
                        status_reg <= STATUS_NOSPACE;
                end
            end
            CMD_MARK:
            begin
                word_idx_reg <= WORD_W'(word_idx_reg + 1'b1);
                if ((kind_reg == KIND_FREE) && dup_c)
                    status_reg <= STATUS_BADFREE;
            end
            CMD_PUBLISH:
            begin
                out_reg.status          <= status_reg;
                out_reg.granted_address <= grant_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/core/bitmap_page_run_allocator_top.sv =====
// Top level of the bitmap first-fit page run allocator
// A first-fit page allocator over a heap of PAGE_COUNT pages of PAGE_BYTES bytes starting
// at heap_base, tracked by a free bitmap (bit set = page free) that reset sets all free.
// An allocate word rounds request_bytes up to pages and claims the lowest run of that
// many free pages, answering heap_base plus the run offset; a zero-page allocate answers
// the first free page and claims nothing. A free word returns a page-aligned region to
// the bitmap; misaligned or out-of-range frees are rejected with no change, and freeing
// a page that is already free still marks it free but reports an invalid free. One word
// is in work at a time. The steps are accept, range check, then for an allocate a
// search over up to MAP_WORDS bitmap words (32 with the default 1024 pages), then the
// marking of each bitmap word that the run touches, then the load of the output register
// once it has room. The search inspects one 32-page bitmap word per cycle, and marking
// rewrites one word per cycle. The next word is accepted as soon as the previous result
// sits in the output register, even if it is not yet taken.
// heap_base may only be written while no word is in work.
`include "bitmap_page_run_allocator_top_assert.svh"

module bitmap_page_run_allocator_top
    import bpra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  req_t              in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output rsp_t              out_data,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_data
);

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    // sequence accept, check, search, mark and publish
    bpra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    // bitmap, search lanes, marking masks and result registers
    bpra_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dp_cmd),
        .sts      (dp_sts),
        .in_data  (in_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .out_data (out_data)
    );

    // stall new words while one is in work
    `BPRA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    // never overwrite a result that is still waiting
    `BPRA_ASSERT_IMPLY(a_publish_room, clk, rst_n, dp_cmd.op == CMD_PUBLISH, !out_valid || !out_stall)
    // a published result shows up as a valid word
    `BPRA_ASSERT_NEXT(a_publish_valid, clk, rst_n, dp_cmd.op == CMD_PUBLISH, out_valid)

endmodule
